// ===== rtl/mlk_pkg.sv =====
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the code table of the Morse lamp keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

    // Widths of the fixed fields
    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 3;
    localparam int CODE_W    = 5;

    // Defaults for the top level parameters
    localparam int COUNT_BITS_DEF   = 16;
    localparam int MAX_ELEMENTS_DEF = 5;

    // Register reset values, in ticks
    localparam logic [CFG_W-1:0] DOT_RST         = 16'd100;
    localparam logic [CFG_W-1:0] DASH_RST        = 16'd300;
    localparam logic [CFG_W-1:0] ELEM_GAP_RST    = 16'd100;
    localparam logic [CFG_W-1:0] LETTER_GAP_RST  = 16'd300;
    localparam logic [CFG_W-1:0] WORD_GAP_RST    = 16'd700;

    // ASCII landmarks
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;

    typedef enum logic [STATUS_W-1:0] {
        ST_TICK     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_INVALID  = 2'd2,
        ST_REFUSED  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT        = 3'd0,
        CFG_DASH       = 3'd1,
        CFG_ELEM_GAP   = 3'd2,
        CFG_LETTER_GAP = 3'd3,
        CFG_WORD_GAP   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] dot;
        logic [CFG_W-1:0] dash;
        logic [CFG_W-1:0] elem_gap;
        logic [CFG_W-1:0] letter_gap;
        logic [CFG_W-1:0] word_gap;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] character;
    } t_item;

    // len elements, bit 0 of bits is sent first, 1 means dash
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_code;

    typedef struct packed {
        logic  hit;
        t_code code;
    } t_lookup;

    localparam t_code LETTER_CODES [26] = '{
        '{3'd2, 5'd2},  '{3'd4, 5'd1},  '{3'd4, 5'd5},  '{3'd3, 5'd1},
        '{3'd1, 5'd0},  '{3'd4, 5'd4},  '{3'd3, 5'd3},  '{3'd4, 5'd0},
        '{3'd2, 5'd0},  '{3'd4, 5'd14}, '{3'd3, 5'd5},  '{3'd4, 5'd2},
        '{3'd2, 5'd3},  '{3'd2, 5'd1},  '{3'd3, 5'd7},  '{3'd4, 5'd6},
        '{3'd4, 5'd11}, '{3'd3, 5'd2},  '{3'd3, 5'd0},  '{3'd1, 5'd1},
        '{3'd3, 5'd4},  '{3'd4, 5'd8},  '{3'd3, 5'd6},  '{3'd4, 5'd9},
        '{3'd4, 5'd13}, '{3'd4, 5'd3}
    };

    localparam t_code DIGIT_CODES [10] = '{
        '{3'd5, 5'd31}, '{3'd5, 5'd30}, '{3'd5, 5'd28}, '{3'd5, 5'd24},
        '{3'd5, 5'd16}, '{3'd5, 5'd0},  '{3'd5, 5'd1},  '{3'd5, 5'd3},
        '{3'd5, 5'd7},  '{3'd5, 5'd15}
    };

    // Fold case, then look up a letter or digit; hit is low for anything else
    function automatic t_lookup f_lookup(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] folded;
        logic [CHAR_W-1:0] letter_off;
        logic [CHAR_W-1:0] digit_off;
        t_lookup           res;
        folded = ch;
        if (ch inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) begin
            folded = ch - CASE_OFFSET;
        end
        letter_off = folded - ASCII_UPPER_A;
        digit_off  = folded - ASCII_ZERO;
        res = '0;
        if (folded inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) begin
            res.hit  = 1'b1;
            res.code = LETTER_CODES[letter_off[4:0]];
        end else if (folded inside {[ASCII_ZERO:ASCII_NINE]}) begin
            res.hit  = 1'b1;
            res.code = DIGIT_CODES[digit_off[3:0]];
        end
        return res;
    endfunction

endpackage

// ===== rtl/mlk_channels.sv =====
// ----------------------------------------------------------------------------
// mlk_channels
// Valid/ready channels of the keyer: input items, result items, register writes.
// ----------------------------------------------------------------------------
interface mlk_in_if;
    import mlk_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output mode, output character, input ready);
    modport sink   (input valid, input mode, input character, output ready);
endinterface

interface mlk_out_if;
    import mlk_pkg::*;

    logic                valid;
    logic                ready;
    logic                lamp;
    logic [STATUS_W-1:0] status;
    logic                busy_res;

    modport source (output valid, output lamp, output status, output busy_res, input ready);
    modport sink   (input valid, input lamp, input status, input busy_res, output ready);
endinterface

interface mlk_cfg_if;
    import mlk_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mlk_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mlk_cfg_regs
// Timing registers of the keyer, written through the register channel.
// ----------------------------------------------------------------------------
module mlk_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mlk_cfg_if.sink       i_cfg,
    output mlk_pkg::t_cfg o_cfg
);
    import mlk_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot        <= DOT_RST;
            r_cfg.dash       <= DASH_RST;
            r_cfg.elem_gap   <= ELEM_GAP_RST;
            r_cfg.letter_gap <= LETTER_GAP_RST;
            r_cfg.word_gap   <= WORD_GAP_RST;
        end else if (i_cfg.valid) begin
            // drop writes beyond the register list
            case (t_cfg_idx'(i_cfg.index))
                CFG_DOT:        r_cfg.dot        <= i_cfg.data;
                CFG_DASH:       r_cfg.dash       <= i_cfg.data;
                CFG_ELEM_GAP:   r_cfg.elem_gap   <= i_cfg.data;
                CFG_LETTER_GAP: r_cfg.letter_gap <= i_cfg.data;
                CFG_WORD_GAP:   r_cfg.word_gap   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/mlk_in_stage.sv =====
// ----------------------------------------------------------------------------
// mlk_in_stage
// Input register: holds one item until the keyer core takes it.
// ----------------------------------------------------------------------------
module mlk_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mlk_in_if.sink         i_in,
    input  logic           i_take,
    output logic           o_valid,
    output mlk_pkg::t_item o_item
);
    import mlk_pkg::*;

    logic  r_valid;
    t_item r_item;

    // refill in the same cycle the held item moves on
    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.mode      <= i_in.mode;
            r_item.character <= i_in.character;
        end
    end

endmodule

// ===== rtl/mlk_core.sv =====
// ----------------------------------------------------------------------------
// mlk_core
// Keying state machine and result register: one item per step.
// ----------------------------------------------------------------------------
module mlk_core #(
    parameter int COUNT_BITS   = mlk_pkg::COUNT_BITS_DEF,
    parameter int MAX_ELEMENTS = mlk_pkg::MAX_ELEMENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mlk_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  mlk_pkg::t_item i_item,
    output logic           o_take,
    mlk_out_if.source      o_out
);
    import mlk_pkg::*;

    localparam int EL_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SAT_W = CFG_W + COUNT_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MARK,
        PH_ELEM_GAP,
        PH_LETTER_GAP,
        PH_WORD_GAP
    } t_phase;

    t_phase                  r_phase,   n_phase;
    logic [COUNT_BITS-1:0]   r_ticks,   n_ticks;
    logic [MAX_ELEMENTS-1:0] r_pattern, n_pattern;
    logic [EL_W-1:0]         r_elems,   n_elems;
    logic                    r_after,   n_after;
    logic                    r_lamp,    n_lamp;
    t_status                 n_status;

    logic                    r_out_valid;
    logic                    r_out_lamp;
    t_status                 r_out_status;
    logic                    r_out_busy;

    logic                    step;
    logic [EL_W-1:0]         elems_dec;
    t_lookup                 look;

    // Saturate a register value to the countdown width
    function automatic logic [COUNT_BITS-1:0] f_load(input logic [CFG_W-1:0] v);
        logic [SAT_W-1:0] wide;
        logic [SAT_W-1:0] limit;
        wide  = SAT_W'(v);
        limit = SAT_W'({COUNT_BITS{1'b1}});
        if (wide > limit) begin
            return '1;
        end
        return wide[COUNT_BITS-1:0];
    endfunction

    assign step   = i_valid && (!r_out_valid || o_out.ready);
    assign o_take = step;

    assign o_out.valid    = r_out_valid;
    assign o_out.lamp     = r_out_lamp;
    assign o_out.status   = r_out_status;
    assign o_out.busy_res = r_out_busy;

    always_comb begin
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_pattern = r_pattern;
        n_elems   = r_elems;
        n_after   = r_after;
        n_lamp    = r_lamp;
        n_status  = ST_TICK;
        elems_dec = (r_elems != '0) ? r_elems - EL_W'(1) : '0;
        look      = f_lookup(i_item.character);

        if (i_item.mode) begin
            if (r_phase != PH_IDLE) begin
                if (r_ticks > COUNT_BITS'(1)) begin
                    n_ticks = r_ticks - COUNT_BITS'(1);
                end else begin
                    n_ticks = '0;
                    case (r_phase)
                        PH_MARK: begin
                            n_lamp    = 1'b0;
                            n_pattern = r_pattern >> 1;
                            n_elems   = elems_dec;
                            if (elems_dec == '0) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_ELEM_GAP;
                                n_ticks = f_load(i_cfg.elem_gap);
                            end
                        end
                        PH_ELEM_GAP, PH_LETTER_GAP: begin
                            if (r_elems == '0) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_MARK;
                                n_lamp  = 1'b1;
                                n_ticks = f_load(r_pattern[0] ? i_cfg.dash : i_cfg.dot);
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_lamp  = 1'b0;
                        end
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_status = ST_REFUSED;
        end else if (look.hit) begin
            n_status  = ST_ACCEPTED;
            n_pattern = MAX_ELEMENTS'(look.code.bits);
            n_elems   = EL_W'(look.code.len);
            n_after   = 1'b1;
            if (r_after) begin
                n_phase = PH_LETTER_GAP;
                n_lamp  = 1'b0;
                n_ticks = f_load(i_cfg.letter_gap);
            end else begin
                n_phase = PH_MARK;
                n_lamp  = 1'b1;
                n_ticks = f_load(look.code.bits[0] ? i_cfg.dash : i_cfg.dot);
            end
        end else if (i_item.character == ASCII_SPACE) begin
            n_status = ST_ACCEPTED;
            n_phase  = PH_WORD_GAP;
            n_lamp   = 1'b0;
            n_ticks  = f_load(i_cfg.word_gap);
            n_after  = 1'b0;
        end else begin
            n_status = ST_INVALID;
            n_after  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_pattern   <= '0;
            r_elems     <= '0;
            r_after     <= 1'b0;
            r_lamp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase      <= n_phase;
                r_ticks      <= n_ticks;
                r_pattern    <= n_pattern;
                r_elems      <= n_elems;
                r_after      <= n_after;
                r_lamp       <= n_lamp;
                r_out_valid  <= 1'b1;
                r_out_lamp   <= n_lamp;
                r_out_status <= n_status;
                r_out_busy   <= (n_phase != PH_IDLE);
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/morse_lamp_keyer.sv =====
// ----------------------------------------------------------------------------
// morse_lamp_keyer
// Drives one lamp with International Morse code from character and tick items.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items: mode 0 sends the ASCII character, mode 1 is one
//   time tick. Letters (either case) and digits are keyed, a space gives a
//   dark word gap, anything else returns status invalid. A character sent
//   while an element or gap is still running is refused and changes nothing.
//   o_out returns exactly one result item per input item, in order: the lamp
//   after that item, the status and whether keying is still busy.
//   i_cfg writes the five timing registers (dot, dash, element gap, letter
//   gap, word gap, index 0 to 4); other indexes are ignored. It is always
//   ready; write it only while no item is in flight.
// Timing:
//   An item goes through the input register and one pass of the keying
//   logic into the result register: its result item is loaded when the
//   core takes the item from the input register. One item is taken every
//   cycle unless o_out is held off, set by the single countdown and phase
//   update per item.
// Reset (synchronous, active low): lamp dark, keyer idle, registers back to
//   their defaults, both item registers empty.
// Stall: when o_out is held off, the result register keeps its item and the
//   input register takes one more; after that i_in.ready drops.
// ----------------------------------------------------------------------------
module morse_lamp_keyer #(
    parameter int COUNT_BITS   = mlk_pkg::COUNT_BITS_DEF,
    parameter int MAX_ELEMENTS = mlk_pkg::MAX_ELEMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlk_in_if.sink    i_in,
    mlk_out_if.source o_out,
    mlk_cfg_if.sink   i_cfg
);
    import mlk_pkg::*;

    t_cfg  cfg;          // current timing registers
    t_item item;         // item waiting in the input register
    logic  item_valid;
    logic  item_take;    // core consumes the held item this cycle

    // timing registers
    mlk_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // hold the incoming item; refill as soon as it moves on
    mlk_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (item_take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // advance the keying state and register the result item
    mlk_core #(
        .COUNT_BITS   (COUNT_BITS),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (item_valid),
        .i_item  (item),
        .o_take  (item_take),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/mlk_checker.sv =====
// ----------------------------------------------------------------------------
// mlk_checker
// Port-level checks of the keyer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mlk_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_lamp,
    input logic [mlk_pkg::STATUS_W-1:0] i_status,
    input logic                         i_busy_res
);
    import mlk_pkg::*;

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_lamp, i_status, i_busy_res}))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // a lit lamp only happens inside an element
    a_lamp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_lamp |-> i_busy_res)
        else $error("lamp lit while idle");

    // an accepted character always starts an element or gap
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_ACCEPTED) |-> i_busy_res)
        else $error("accepted character left keyer idle");

    // an invalid character is only judged while idle and leaves it idle
    a_invalid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_INVALID) |-> !i_busy_res && !i_lamp)
        else $error("invalid character changed keying");

endmodule

bind morse_lamp_keyer mlk_checker u_mlk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_lamp      (o_out.lamp),
    .i_status    (o_out.status),
    .i_busy_res  (o_out.busy_res)
);

// ===== dv/morse_lamp_keyer_tb.sv =====
// ----------------------------------------------------------------------------
// morse_lamp_keyer_tb
// Self-checking bench for the Morse lamp keyer: character and tick items go
// in through a valid/ready driver with random gaps. An item-level model of
// the keyer predicts lamp, status and busy for every accepted item, and a
// monitor compares each result item in order against that prediction.
// ----------------------------------------------------------------------------
module morse_lamp_keyer_tb;
    import mlk_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 12;
    localparam int MAX_IDLE          = 5;
    localparam int LONG_STALL_CYCLES = 80;
    localparam int SETTLE_CYCLES     = 4;
    localparam int DRAIN_CYCLES      = 8;
    localparam int RANDOM_RUN        = 100;
    localparam int FULL_SCALE_TICKS  = 8;
    localparam int PRINT_CAP         = 50;
    localparam int TIMEOUT_UNITS     = 2_000_000;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [CFG_W-1:0]     TICKS_MAX    = '1;
    // first index past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic [2:0] {
        KEY_IDLE,
        KEY_MARK,
        KEY_ELEM_GAP,
        KEY_LETTER_GAP,
        KEY_WORD_GAP
    } t_key_phase;

    typedef struct packed {
        logic    lamp;
        t_status status;
        logic    busy;
    } t_lamp_result;

    // {element count, pattern}; pattern bit 0 goes first, 1 is a dash
    localparam logic [7:0] LETTER_TAB [0:25] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},
        {3'd1, 5'd0},  {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},
        {3'd2, 5'd0},  {3'd4, 5'd14}, {3'd3, 5'd5},  {3'd4, 5'd2},
        {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},  {3'd4, 5'd6},
        {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},
        {3'd4, 5'd13}, {3'd4, 5'd3}
    };
    localparam logic [7:0] DIGIT_TAB [0:9] = '{
        {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24},
        {3'd5, 5'd16}, {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},
        {3'd5, 5'd7},  {3'd5, 5'd15}
    };

    logic i_clk;
    logic i_rst_n;

    mlk_in_if  in_ch ();
    mlk_out_if out_ch ();
    mlk_cfg_if cfg_ch ();

    morse_lamp_keyer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Items waiting for the driver, and predictions waiting for results
    t_item        send_queue [$];
    t_lamp_result pending_results [$];

    // Handshakes seen at the last rising edge, read by the falling-edge drivers
    bit in_taken;
    bit out_taken;

    // Idling knobs, changed by the stimulus only around rising edges
    bit send_idle_on;
    bit recv_idle_on;
    bit rx_frozen;
    int unsigned send_wait;
    int unsigned recv_wait;

    int unsigned mismatches;
    int unsigned results_seen;

    event stall_kick;

    // Keyer state as predicted, updated at each accepted item
    t_key_phase          key_phase;
    logic [CFG_W-1:0]    key_ticks;
    logic [CODE_W-1:0]   key_pattern;
    logic [LEN_W-1:0]    key_elems;
    logic                key_after;
    logic                key_lamp;
    t_cfg                key_timing;

    // Stimulus-side view: ticks until the keyer goes idle, and letter-gap flag
    int unsigned plan_busy;
    bit          plan_after;
    t_cfg        plan_timing;

    // ------------------------------------------------------------------
    // Code lookup: fold lower case, then letters and digits; miss otherwise
    // ------------------------------------------------------------------
    function automatic logic lookup_morse(input logic [CHAR_W-1:0] ch,
                                          output logic [LEN_W-1:0] len,
                                          output logic [CODE_W-1:0] bits);
        logic [CHAR_W-1:0] up;
        logic [7:0]        entry;
        up    = ch;
        len   = '0;
        bits  = '0;
        entry = '0;
        if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
            up = ch - CASE_OFFSET;
        end
        if (up >= ASCII_UPPER_A && up <= ASCII_UPPER_Z) begin
            entry = LETTER_TAB[up - ASCII_UPPER_A];
        end else if (up >= ASCII_ZERO && up <= ASCII_NINE) begin
            entry = DIGIT_TAB[up - ASCII_ZERO];
        end else begin
            return 1'b0;
        end
        {len, bits} = entry;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Keyer prediction
    // ------------------------------------------------------------------
    function automatic void key_reset();
        key_phase   = KEY_IDLE;
        key_ticks   = '0;
        key_pattern = '0;
        key_elems   = '0;
        key_after   = 1'b0;
        key_lamp    = 1'b0;
        key_timing  = '{dot: DOT_RST, dash: DASH_RST, elem_gap: ELEM_GAP_RST,
                        letter_gap: LETTER_GAP_RST, word_gap: WORD_GAP_RST};
    endfunction

    function automatic void key_start_mark();
        key_phase = KEY_MARK;
        key_lamp  = 1'b1;
        key_ticks = key_pattern[0] ? key_timing.dash : key_timing.dot;
    endfunction

    // One tick: count down, and on the last tick of a segment move on.
    // A loaded zero behaves like one, since the test is "more than one left".
    function automatic void key_tick();
        if (key_phase == KEY_IDLE) begin
            return;
        end
        if (key_ticks > 1) begin
            key_ticks = key_ticks - 1'b1;
            return;
        end
        key_ticks = '0;
        case (key_phase)
            KEY_MARK: begin
                key_lamp    = 1'b0;
                key_pattern = key_pattern >> 1;
                if (key_elems != 0) begin
                    key_elems = key_elems - 1'b1;
                end
                // no element gap after the last element
                if (key_elems == 0) begin
                    key_phase = KEY_IDLE;
                end else begin
                    key_phase = KEY_ELEM_GAP;
                    key_ticks = key_timing.elem_gap;
                end
            end
            KEY_ELEM_GAP, KEY_LETTER_GAP: begin
                if (key_elems == 0) begin
                    key_phase = KEY_IDLE;
                end else begin
                    key_start_mark();
                end
            end
            default: begin
                key_phase = KEY_IDLE;
                key_lamp  = 1'b0;
            end
        endcase
    endfunction

    function automatic t_lamp_result key_one_item(input logic mode,
                                                  input logic [CHAR_W-1:0] ch);
        t_lamp_result      res;
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
        res.status = ST_TICK;
        if (mode == MODE_TICK) begin
            key_tick();
        end else if (key_phase != KEY_IDLE) begin
            // refused while busy: nothing moves, not even the countdown
            res.status = ST_REFUSED;
        end else begin
            hit = lookup_morse(ch, len, bits);
            if (hit) begin
                res.status  = ST_ACCEPTED;
                key_pattern = bits;
                key_elems   = len;
                if (key_after) begin
                    key_phase = KEY_LETTER_GAP;
                    key_lamp  = 1'b0;
                    key_ticks = key_timing.letter_gap;
                end else begin
                    key_start_mark();
                end
                key_after = 1'b1;
            end else if (ch == ASCII_SPACE) begin
                res.status = ST_ACCEPTED;
                key_phase  = KEY_WORD_GAP;
                key_lamp   = 1'b0;
                key_ticks  = key_timing.word_gap;
                key_after  = 1'b0;
            end else begin
                // invalid: the next symbol starts without a letter gap
                res.status = ST_INVALID;
                key_after  = 1'b0;
            end
        end
        res.lamp = key_lamp;
        res.busy = (key_phase != KEY_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning: track how many ticks the keyer needs to go idle
    // ------------------------------------------------------------------
    function automatic int unsigned seg_ticks(input logic [CFG_W-1:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    function automatic void plan_item(input logic mode, input logic [CHAR_W-1:0] ch);
        t_item             it;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
        int unsigned       total;
        it.mode      = mode;
        it.character = ch;
        send_queue.push_back(it);
        if (mode == MODE_TICK) begin
            if (plan_busy != 0) begin
                plan_busy--;
            end
        end else if (plan_busy == 0) begin
            if (lookup_morse(ch, len, bits)) begin
                total = plan_after ? seg_ticks(plan_timing.letter_gap) : 0;
                for (int i = 0; i < len; i++) begin
                    total += bits[i] ? seg_ticks(plan_timing.dash)
                                     : seg_ticks(plan_timing.dot);
                    if (i + 1 < len) begin
                        total += seg_ticks(plan_timing.elem_gap);
                    end
                end
                plan_busy  = total;
                plan_after = 1'b1;
            end else if (ch == ASCII_SPACE) begin
                plan_busy  = seg_ticks(plan_timing.word_gap);
                plan_after = 1'b0;
            end else begin
                plan_after = 1'b0;
            end
        end
    endfunction

    // Queue ticks with random don't-care characters until the keyer is idle
    function automatic void plan_run_out();
        while (plan_busy != 0) begin
            plan_item(MODE_TICK, 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void plan_char(input logic [CHAR_W-1:0] ch);
        plan_item(MODE_CHAR, ch);
        plan_run_out();
    endfunction

    function automatic logic [CHAR_W-1:0] random_symbol();
        case ($urandom_range(0, 2))
            0:       return ASCII_UPPER_A + 8'($urandom_range(0, 25));
            1:       return ASCII_LOWER_A + 8'($urandom_range(0, 25));
            default: return ASCII_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // Mostly well-formed text: symbols and spaces while idle, ticks while busy.
    // Refused characters and idle ticks are noise and do not count.
    function automatic void plan_random_run(input int unsigned n_items);
        int unsigned counted;
        int unsigned r;
        counted = 0;
        while (counted < n_items) begin
            r = $urandom_range(0, 99);
            if (plan_busy != 0) begin
                if (r < 6) begin
                    plan_item(MODE_CHAR, 8'($urandom_range(0, 255)));
                end else begin
                    plan_item(MODE_TICK, 8'($urandom_range(0, 255)));
                    counted++;
                end
            end else if (r < 60) begin
                plan_item(MODE_CHAR, random_symbol());
                counted++;
            end else if (r < 72) begin
                plan_item(MODE_CHAR, ASCII_SPACE);
                counted++;
            end else if (r < 86) begin
                plan_item(MODE_CHAR, 8'($urandom_range(0, 255)));
                counted++;
            end else begin
                plan_item(MODE_TICK, 8'($urandom_range(0, 255)));
            end
        end
        plan_run_out();
    endfunction

    // ------------------------------------------------------------------
    // Register writes, only with no item in flight
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_DOT:        plan_timing.dot        = val;
            CFG_DASH:       plan_timing.dash       = val;
            CFG_ELEM_GAP:   plan_timing.elem_gap   = val;
            CFG_LETTER_GAP: plan_timing.letter_gap = val;
            CFG_WORD_GAP:   plan_timing.word_gap   = val;
            default: ;
        endcase
    endtask

    // Write all five timings, then garbage to a spare index to catch aliasing
    task automatic set_timing(input logic [CFG_W-1:0] dot, input logic [CFG_W-1:0] dash,
                              input logic [CFG_W-1:0] egap, input logic [CFG_W-1:0] lgap,
                              input logic [CFG_W-1:0] wgap);
        write_reg(CFG_DOT, dot);
        write_reg(CFG_DASH, dash);
        write_reg(CFG_ELEM_GAP, egap);
        write_reg(CFG_LETTER_GAP, lgap);
        write_reg(CFG_WORD_GAP, wgap);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  CFG_W'($urandom_range(0, 65535)));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold until everything queued has gone in and every result has come back
    task automatic wait_quiet();
        while (send_queue.size() != 0 || in_ch.valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("MISMATCH %s: got %0d, want %0d (result %0d)",
                     what, got, want, results_seen);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #TIMEOUT_UNITS;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here so the sender keeps offering
    // ------------------------------------------------------------------
    always begin : long_stall
        @(stall_kick);
        @(posedge i_clk);
        rx_frozen = 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge i_clk);
        rx_frozen = 1'b0;
    end

    // ------------------------------------------------------------------
    // Item driver: present the next queued item at the falling edge, after
    // a random gap once the previous one has been taken. valid gets exactly
    // one assignment per edge so back-to-back items keep it high.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : item_sender
        logic  offer;
        t_item nxt;
        offer = in_ch.valid;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (offer && in_taken) begin
                offer     = 1'b0;
                send_wait = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (!offer) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else if (send_queue.size() != 0) begin
                    nxt = send_queue.pop_front();
                    in_ch.mode      <= nxt.mode;
                    in_ch.character <= nxt.character;
                    offer = 1'b1;
                end
            end
        end
        in_ch.valid <= offer;
    end

    // ------------------------------------------------------------------
    // Result taker: after each result, hold ready low for a random number
    // of cycles in which a result is actually waiting.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_taker
        logic take;
        if (!i_rst_n) begin
            take = 1'b0;
        end else begin
            if (out_taken) begin
                recv_wait = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rx_frozen) begin
                take = 1'b0;
            end else if (recv_wait != 0) begin
                take = 1'b0;
                if (out_ch.valid) begin
                    recv_wait--;
                end
            end else begin
                take = 1'b1;
            end
        end
        out_ch.ready <= take;
    end

    // ------------------------------------------------------------------
    // Monitor: apply register writes and accepted items to the prediction,
    // then check each result item against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : lamp_checker
        t_lamp_result want;
        in_taken  = i_rst_n && in_ch.valid && in_ch.ready;
        out_taken = i_rst_n && out_ch.valid && out_ch.ready;
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                CFG_DOT:        key_timing.dot        = cfg_ch.data;
                CFG_DASH:       key_timing.dash       = cfg_ch.data;
                CFG_ELEM_GAP:   key_timing.elem_gap   = cfg_ch.data;
                CFG_LETTER_GAP: key_timing.letter_gap = cfg_ch.data;
                CFG_WORD_GAP:   key_timing.word_gap   = cfg_ch.data;
                default: ;
            endcase
        end
        if (in_taken) begin
            pending_results.push_back(key_one_item(in_ch.mode, in_ch.character));
        end
        if (out_taken) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending, status", out_ch.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.lamp !== want.lamp) begin
                    flag_mismatch("lamp", out_ch.lamp, want.lamp);
                end
                if (out_ch.status !== want.status) begin
                    flag_mismatch("status", out_ch.status, want.status);
                end
                if (out_ch.busy_res !== want.busy) begin
                    flag_mismatch("busy_res", out_ch.busy_res, want.busy);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_CHAR;
        in_ch.character = '0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_DOT;
        cfg_ch.data     = '0;
        send_idle_on    = 1'b1;
        recv_idle_on    = 1'b1;
        rx_frozen       = 1'b0;
        send_wait       = 0;
        recv_wait       = 0;
        mismatches      = 0;
        results_seen    = 0;
        plan_busy       = 0;
        plan_after      = 1'b0;
        key_reset();
        plan_timing = key_timing;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (!i_rst_n) @(posedge i_clk);

        // Reset timings: idle tick, a dot, then a dash with no letter gap.
        // Freeze the receiver while the sender keeps pushing, so the block
        // fills up and drops its ready.
        plan_item(MODE_TICK, '0);
        plan_char("E");
        plan_char(8'h00);               // invalid, clears the letter gap
        plan_char("T");
        -> stall_kick;
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Directed: field extremes, case folding, range edges, busy refusal
        set_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
        plan_item(MODE_TICK, 8'hFF);
        plan_char(8'h00);
        plan_char(8'hFF);
        plan_char("e");
        plan_char("T");                 // letter gap after a symbol
        plan_char(ASCII_UPPER_A - 8'd1);
        plan_char("z");                 // no letter gap after an invalid
        plan_char(ASCII_UPPER_Z + 8'd1);
        plan_char(ASCII_LOWER_A - 8'd1);
        plan_char(ASCII_LOWER_Z + 8'd1);
        plan_char(ASCII_ZERO - 8'd1);
        plan_char(ASCII_NINE + 8'd1);
        plan_char("0");
        plan_item(MODE_CHAR, "A");
        plan_item(MODE_TICK, '0);
        plan_item(MODE_CHAR, "S");      // refused while keying
        plan_item(MODE_CHAR, ASCII_SPACE);
        plan_run_out();
        plan_char(ASCII_SPACE);
        plan_char("9");
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Random text under several timing settings
        set_timing(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 4)),
                   CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 4)),
                   CFG_W'($urandom_range(1, 4)));
        plan_random_run(RANDOM_RUN);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Zero durations act as one tick; run the sender flat out
        send_idle_on = 1'b0;
        set_timing('0, '0, '0, '0, '0);
        plan_random_run(RANDOM_RUN);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Standard 1:3:1:3:7 ratios; receiver always ready
        send_idle_on = 1'b1;
        recv_idle_on = 1'b0;
        set_timing(16'd1, 16'd3, 16'd1, 16'd3, 16'd7);
        plan_random_run(RANDOM_RUN);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        recv_idle_on = 1'b1;
        set_timing(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)),
                   CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)),
                   CFG_W'($urandom_range(0, 6)));
        plan_random_run(RANDOM_RUN);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Full-scale counts: load the top count, tick into it and refuse a
        // character; the run ends with the keyer still busy
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        set_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        plan_item(MODE_CHAR, "E");
        repeat (FULL_SCALE_TICKS) plan_item(MODE_TICK, '0);
        plan_item(MODE_CHAR, "T");
        wait_quiet();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mlk_pkg.sv
rtl/mlk_channels.sv
rtl/mlk_cfg_regs.sv
rtl/mlk_in_stage.sv
rtl/mlk_core.sv
rtl/morse_lamp_keyer.sv
rtl/mlk_checker.sv
dv/morse_lamp_keyer_tb.sv
